### hw/rtl/ota_pkg.sv
// ota_pkg: shared types and constants of the ota image stream extractor
// no dependencies; imported by ota_front, ota_back and the top level
`timescale 1ns / 1ps

package ota_pkg;

  localparam int unsigned HEADER_FIXED_BYTES = 56;
  localparam int unsigned ELEM_HDR_BYTES = 6;
  localparam int unsigned HDR_LEN_LO_OFF = 6;
  localparam int unsigned HDR_LEN_HI_OFF = 7;
  localparam int unsigned PART_SIZE_W = 25;
  localparam logic [PART_SIZE_W-1:0] PART_SIZE_RESET = 25'd1572864;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_ABORT = 2'd3
  } ota_cmd_e;

  typedef enum logic [1:0] {
    STG_FIXED   = 2'd0,
    STG_SKIP    = 2'd1,
    STG_EHDR    = 2'd2,
    STG_PAYLOAD = 2'd3
  } ota_stage_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_NOT_STARTED = 3'd1,
    STAT_OFFSET      = 3'd2,
    STAT_TOO_LARGE   = 3'd3,
    STAT_MISMATCH    = 3'd4
  } ota_status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic        block_start;
    logic [31:0] block_offset;
    logic [31:0] total_size;
  } ota_in_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic        active;
    logic [31:0] bytes_written;
  } ota_out_t;

  typedef struct packed {
    ota_cmd_e    cmd;
    logic [7:0]  data_byte;
    logic        block_start;
    logic [31:0] block_offset;
    logic [31:0] total_size;
  } ota_op_t;

endpackage

### hw/rtl/ota_fifo.sv
// ota_fifo: small register queue with full and empty flags
// standalone; used by the front and back parts of the extractor
`timescale 1ns / 1ps

module ota_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### hw/rtl/ota_front.sv
// ota_front: accepts input items, decodes the command and queues them
// depends on ota_pkg and ota_fifo
`timescale 1ns / 1ps

module ota_front
  import ota_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ota_in_t item_i,
  input  logic    push_i,
  output logic    full_o,
  output ota_op_t op_o,
  output logic    op_valid_o,
  input  logic    op_take_i
);

  ota_op_t                op_in;
  logic [$bits(ota_op_t)-1:0] op_rdata;
  logic                   op_empty;

  always_comb begin
    op_in.cmd          = ota_cmd_e'(item_i.command);
    op_in.data_byte    = item_i.data_byte;
    op_in.block_start  = item_i.block_start;
    op_in.block_offset = item_i.block_offset;
    op_in.total_size   = item_i.total_size;
  end

  ota_fifo #(
    .Width($bits(ota_op_t)),
    .Depth(Depth)
  ) u_op_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(op_in),
    .full_o (full_o),
    .pop_i  (op_take_i),
    .rdata_o(op_rdata),
    .empty_o(op_empty)
  );

  assign op_o       = op_rdata;
  assign op_valid_o = !op_empty;

endmodule

### hw/rtl/ota_back.sv
// ota_back: parser state, partition size register and result queue
// depends on ota_pkg and ota_fifo
`timescale 1ns / 1ps

module ota_back
  import ota_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ota_op_t                op_i,
  input  logic                   op_valid_i,
  output logic                   op_take_o,
  input  logic                   cfg_we_i,
  input  logic [PART_SIZE_W-1:0] cfg_wdata_i,
  output ota_out_t               result_o,
  output logic                   empty_o,
  input  logic                   pop_i
);

  ota_stage_e             stage_q, stage_d;
  logic [31:0]            stage_off_q, stage_off_d;
  logic [31:0]            file_pos_q, file_pos_d;
  logic [15:0]            hdr_len_q, hdr_len_d;
  logic [15:0]            elem_tag_q, elem_tag_d;
  logic [31:0]            elem_end_q, elem_end_d;
  logic [31:0]            exp_size_q, exp_size_d;
  logic                   in_prog_q, in_prog_d;
  logic [31:0]            wr_count_q, wr_count_d;
  logic [PART_SIZE_W-1:0] part_size_q;

  logic        res_full;
  logic        emit;
  logic        clear;
  ota_status_e status;
  logic [31:0] off_inc, pos_inc;
  ota_out_t    res;
  logic [$bits(ota_out_t)-1:0] res_rdata;

  assign op_take_o = op_valid_i && !res_full;
  assign off_inc   = stage_off_q + 32'd1;
  assign pos_inc   = file_pos_q + 32'd1;

  always_comb begin
    stage_d     = stage_q;
    stage_off_d = stage_off_q;
    file_pos_d  = file_pos_q;
    hdr_len_d   = hdr_len_q;
    elem_tag_d  = elem_tag_q;
    elem_end_d  = elem_end_q;
    exp_size_d  = exp_size_q;
    in_prog_d   = in_prog_q;
    wr_count_d  = wr_count_q;
    status      = STAT_OK;
    emit        = 1'b0;
    clear       = 1'b0;

    case (op_i.cmd)
      CMD_START: begin
        clear = 1'b1;
      end
      CMD_DATA: begin
        if (!in_prog_q) begin
          status = STAT_NOT_STARTED;
        end else if (op_i.block_start && (op_i.block_offset != file_pos_q)) begin
          status = STAT_OFFSET;
          clear  = 1'b1;
        end else begin
          case (stage_q)
            STG_FIXED: begin
              if (stage_off_q == 32'(HDR_LEN_LO_OFF)) begin
                hdr_len_d[7:0] = op_i.data_byte;
              end else if (stage_off_q == 32'(HDR_LEN_HI_OFF)) begin
                hdr_len_d[15:8] = op_i.data_byte;
              end
              stage_off_d = off_inc;
              file_pos_d  = pos_inc;
              if (off_inc >= 32'(HEADER_FIXED_BYTES)) begin
                stage_off_d = '0;
                stage_d = (pos_inc < {16'd0, hdr_len_d}) ? STG_SKIP : STG_EHDR;
              end
            end
            STG_SKIP: begin
              stage_off_d = off_inc;
              file_pos_d  = pos_inc;
              if (pos_inc >= {16'd0, hdr_len_q}) begin
                stage_off_d = '0;
                stage_d     = STG_EHDR;
              end
            end
            STG_EHDR: begin
              case (stage_off_q[2:0])
                3'd0: begin
                  elem_tag_d = {8'd0, op_i.data_byte};
                  elem_end_d = '0;
                end
                3'd1: elem_tag_d[15:8] = op_i.data_byte;
                3'd2: elem_end_d[7:0] = op_i.data_byte;
                3'd3: elem_end_d[15:8] = op_i.data_byte;
                3'd4: elem_end_d[23:16] = op_i.data_byte;
                3'd5: elem_end_d[31:24] = op_i.data_byte;
                default: begin
                end
              endcase
              stage_off_d = off_inc;
              file_pos_d  = pos_inc;
              if (off_inc >= 32'(ELEM_HDR_BYTES)) begin
                stage_off_d = '0;
                stage_d = (elem_end_d == '0) ? STG_EHDR : STG_PAYLOAD;
              end
            end
            default: begin
              if ((elem_tag_q == '0) &&
                  (elem_end_q > {{(32 - PART_SIZE_W){1'b0}}, part_size_q})) begin
                status = STAT_TOO_LARGE;
                clear  = 1'b1;
              end else begin
                if (elem_tag_q == '0) begin
                  emit       = 1'b1;
                  wr_count_d = wr_count_q + 32'd1;
                end
                stage_off_d = off_inc;
                file_pos_d  = pos_inc;
                if (off_inc >= elem_end_q) begin
                  stage_off_d = '0;
                  stage_d     = STG_EHDR;
                end
              end
            end
          endcase
        end
      end
      CMD_CHECK: begin
        if (!in_prog_q) begin
          status = STAT_NOT_STARTED;
        end else if (file_pos_q != exp_size_q) begin
          status = STAT_MISMATCH;
          clear  = 1'b1;
        end
      end
      default: begin
        clear = 1'b1;
      end
    endcase

    if (clear) begin
      stage_d     = STG_FIXED;
      stage_off_d = '0;
      file_pos_d  = '0;
      hdr_len_d   = '0;
      elem_tag_d  = '0;
      elem_end_d  = '0;
      exp_size_d  = '0;
      in_prog_d   = 1'b0;
    end
    if (op_i.cmd == CMD_START) begin
      in_prog_d  = 1'b1;
      wr_count_d = '0;
      exp_size_d = op_i.total_size;
    end

    res.payload_valid = emit;
    res.payload_byte  = emit ? op_i.data_byte : 8'd0;
    res.status        = status;
    res.active        = in_prog_d;
    res.bytes_written = wr_count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= STG_FIXED;
      stage_off_q <= '0;
      file_pos_q  <= '0;
      hdr_len_q   <= '0;
      elem_tag_q  <= '0;
      elem_end_q  <= '0;
      exp_size_q  <= '0;
      in_prog_q   <= 1'b0;
      wr_count_q  <= '0;
    end else if (op_take_o) begin
      stage_q     <= stage_d;
      stage_off_q <= stage_off_d;
      file_pos_q  <= file_pos_d;
      hdr_len_q   <= hdr_len_d;
      elem_tag_q  <= elem_tag_d;
      elem_end_q  <= elem_end_d;
      exp_size_q  <= exp_size_d;
      in_prog_q   <= in_prog_d;
      wr_count_q  <= wr_count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_size_q <= PART_SIZE_RESET;
    end else if (cfg_we_i) begin
      part_size_q <= cfg_wdata_i;
    end
  end

  ota_fifo #(
    .Width($bits(ota_out_t)),
    .Depth(Depth)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (op_take_o),
    .wdata_i(res),
    .full_o (res_full),
    .pop_i  (pop_i),
    .rdata_o(res_rdata),
    .empty_o(empty_o)
  );

  assign result_o = res_rdata;

endmodule

### hw/rtl/ota_image_stream_extractor.sv
// ota_image_stream_extractor: top level, ota file parser with queue ports
// path: an accepted item waits in the front queue; its result enters the result queue when the back part takes it
// throughput: one item per cycle while the result queue has room, as the back part updates the parser per item taken
// reset: rst_ni low clears parser and queues at once, partition size to 1572864
// no clearing pass; items are accepted in the first cycle after reset
`timescale 1ns / 1ps

module ota_image_stream_extractor
  import ota_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ota_in_t                item_i,
  input  logic                   push,
  output logic                   full,
  output ota_out_t               result_o,
  output logic                   empty,
  input  logic                   pop,
  input  logic                   cfg_we_i,
  input  logic [PART_SIZE_W-1:0] cfg_wdata_i
);

  ota_op_t op;
  logic    op_valid;
  logic    op_take;

  ota_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .push_i    (push),
    .full_o    (full),
    .op_o      (op),
    .op_valid_o(op_valid),
    .op_take_i (op_take)
  );

  ota_back #(
    .Depth(QueueDepth)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .op_valid_i (op_valid),
    .op_take_o  (op_take),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .result_o   (result_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

  // an emitted byte always comes with ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.payload_valid) |-> (result_o.status == STAT_OK))
    else $error("payload emitted with error status");

  // a non-emitted item carries a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.payload_valid) |-> (result_o.payload_byte == 8'd0))
    else $error("payload byte not zero");

  // errors on a running transfer leave it inactive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (result_o.status == STAT_OFFSET || result_o.status == STAT_TOO_LARGE ||
                result_o.status == STAT_MISMATCH)) |-> !result_o.active)
    else $error("transfer still active after error");

  // the back part only takes an item that the front holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_take |-> op_valid)
    else $error("item taken from empty front queue");

endmodule
